### rtl/edtp_pkg.sv
// edtp_pkg: shared widths, constants and codes of the departure-time pacer
// no dependencies; imported by every other file of the block but edtp_ram
`timescale 1ns / 1ps

package edtp_pkg;

  // payload field widths
  localparam int unsigned FLOW_IDX_W = 8;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned HOR_W      = 32;
  localparam int unsigned VERDICT_W  = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = HOR_W;

  // gap arithmetic: length * 1e9 fits in LEN_W + NS_W bits
  localparam int unsigned NS_W  = 30;
  localparam int unsigned DVD_W = LEN_W + NS_W;
  localparam logic [NS_W-1:0] NS_PER_SECOND = NS_W'(1000000000);

  localparam logic [HOR_W-1:0] DROP_HORIZON_RESET = HOR_W'(2000000000);
  localparam logic [HOR_W-1:0] MARK_HORIZON_RESET = HOR_W'(500000000);

  localparam int unsigned FLOW_COUNT_DEF = 256;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_PACED = 2'd1,
    VERDICT_DROP  = 2'd2
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROP_HORIZON = 1'b0,
    CFG_MARK_HORIZON = 1'b1
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_step;
    logic load;
    logic div_step;
    logic sum;
    logic compare;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bypass_in;
    logic clear_last;
    logic div_last;
    logic out_busy;
  } dp_sts_t;

endpackage

### rtl/edtp_in_if.sv
// edtp_in_if: packet descriptor channel of the pacer, valid/ready
// depends on edtp_pkg for field widths
`timescale 1ns / 1ps

interface edtp_in_if import edtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FLOW_IDX_W-1:0] flow_index;
  logic                  flow_known;
  logic [RATE_W-1:0]     rate_bytes_per_sec;
  logic [LEN_W-1:0]      packet_length;
  logic [TIME_W-1:0]     packet_time_ns;
  logic [TIME_W-1:0]     now_ns;

  modport source (
    output valid, flow_index, flow_known, rate_bytes_per_sec, packet_length,
           packet_time_ns, now_ns,
    input  ready
  );

  modport sink (
    input  valid, flow_index, flow_known, rate_bytes_per_sec, packet_length,
           packet_time_ns, now_ns,
    output ready
  );
endinterface

### rtl/edtp_out_if.sv
// edtp_out_if: verdict channel of the pacer, valid/ready
// depends on edtp_pkg for field widths
`timescale 1ns / 1ps

interface edtp_out_if import edtp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic                 ce_mark;
  logic [TIME_W-1:0]    departure_ns;

  modport source (
    output valid, verdict, ce_mark, departure_ns,
    input  ready
  );

  modport sink (
    input  valid, verdict, ce_mark, departure_ns,
    output ready
  );
endinterface

### rtl/edtp_ram.sv
// edtp_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module edtp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/edtp_ctrl.sv
// edtp_ctrl: sequencing state machine of the pacer
// depends on edtp_pkg for command and status structs
`timescale 1ns / 1ps

module edtp_ctrl import edtp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LOAD   = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_SUM    = 7'b0010000,
    ST_CMP    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.bypass_in ? ST_FINISH : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for room in the output register
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/edtp_dp.sv
// edtp_dp: pacer datapath: flow store, gap divider, compares, result register
// depends on edtp_pkg and edtp_ram
`timescale 1ns / 1ps

module edtp_dp import edtp_pkg::*; #(
  parameter int unsigned FLOW_COUNT = FLOW_COUNT_DEF,
  localparam int unsigned SLOT_W    = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  input  logic [HOR_W-1:0]      drop_horizon_i,
  input  logic [HOR_W-1:0]      mark_horizon_i,
  input  logic [FLOW_IDX_W-1:0] flow_index_i,
  input  logic                  flow_known_i,
  input  logic [RATE_W-1:0]     rate_bytes_per_sec_i,
  input  logic [LEN_W-1:0]      packet_length_i,
  input  logic [TIME_W-1:0]     packet_time_ns_i,
  input  logic [TIME_W-1:0]     now_ns_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [VERDICT_W-1:0]  verdict_o,
  output logic                  ce_mark_o,
  output logic [TIME_W-1:0]     departure_ns_o
);

  localparam int unsigned RW      = SLOT_W + FLOW_IDX_W;
  localparam int unsigned ENTRY_W = TIME_W + 1;
  localparam int unsigned DCNT_W  = $clog2(DVD_W);

  // flow index modulo store depth, one conditional subtract per index bit
  function automatic logic [SLOT_W-1:0] flow_slot(input logic [FLOW_IDX_W-1:0] f);
    logic [RW-1:0] r;
    r = RW'(f);
    for (int k = FLOW_IDX_W - 1; k >= 0; k--) begin
      if (r >= (RW'(FLOW_COUNT) << k)) begin
        r = r - (RW'(FLOW_COUNT) << k);
      end
    end
    return r[SLOT_W-1:0];
  endfunction

  // captured descriptor
  logic [SLOT_W-1:0] slot_q;
  logic              bypass_q;
  logic [RATE_W-1:0] rate_q;
  logic [LEN_W-1:0]  len_q;
  logic [TIME_W-1:0] ptime_q;
  logic [TIME_W-1:0] now_q;

  // divider
  logic [DVD_W-1:0]  quo_q;
  logic [RATE_W-1:0] rem_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic [RATE_W:0]   div_shift;
  logic [RATE_W:0]   div_diff;
  logic              div_ge;

  // clearing sweep
  logic [SLOT_W-1:0] clr_cnt_q;

  // decision
  logic [TIME_W-1:0] next_q;
  logic [TIME_W-1:0] eff_q;
  logic              le_q;
  logic [TIME_W-1:0] wait_q;
  logic              drop;
  logic              mark;

  // store
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // result register
  logic              out_valid_q;
  verdict_e          verdict_q, verdict_d;
  logic              ce_q, ce_d;
  logic [TIME_W-1:0] dep_q, dep_d;

  assign sts_o.bypass_in  = !flow_known_i || (rate_bytes_per_sec_i == '0);
  assign sts_o.clear_last = (clr_cnt_q == SLOT_W'(FLOW_COUNT - 1));
  assign sts_o.div_last   = (div_cnt_q == DCNT_W'(DVD_W - 1));
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  // restoring divider step
  assign div_shift = {rem_q, quo_q[DVD_W-1]};
  assign div_diff  = div_shift - {1'b0, rate_q};
  assign div_ge    = (div_shift >= {1'b0, rate_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      slot_q   <= flow_slot(flow_index_i);
      bypass_q <= sts_o.bypass_in;
      rate_q   <= rate_bytes_per_sec_i;
      len_q    <= packet_length_i;
      ptime_q  <= packet_time_ns_i;
      now_q    <= now_ns_i;
    end
    if (cmd_i.load) begin
      quo_q <= DVD_W'(len_q) * DVD_W'(NS_PER_SECOND);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DVD_W-2:0], div_ge};
      rem_q <= div_ge ? div_diff[RATE_W-1:0] : div_shift[RATE_W-1:0];
    end
    if (cmd_i.sum) begin
      next_q <= ram_rdata[TIME_W] ? ram_rdata[TIME_W-1:0] + TIME_W'(quo_q) : '0;
      eff_q  <= (ptime_q < now_q) ? now_q : ptime_q;
    end
    if (cmd_i.compare) begin
      le_q   <= (next_q <= eff_q);
      wait_q <= next_q - now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign drop = (wait_q >= TIME_W'(drop_horizon_i));
  assign mark = (wait_q >= TIME_W'(mark_horizon_i));

  always_comb begin
    verdict_d = VERDICT_PASS;
    ce_d      = 1'b0;
    dep_d     = ptime_q;
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = {1'b1, eff_q};
    if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (!bypass_q) begin
      if (le_q) begin
        ram_we = cmd_i.finish;
      end else if (drop) begin
        verdict_d = VERDICT_DROP;
        dep_d     = '0;
      end else begin
        verdict_d = VERDICT_PACED;
        ce_d      = mark;
        dep_d     = next_q;
        ram_we    = cmd_i.finish;
        ram_wdata = {1'b1, next_q};
      end
    end
  end

  edtp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FLOW_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      verdict_q <= verdict_d;
      ce_q      <= ce_d;
      dep_q     <= dep_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = verdict_q;
  assign ce_mark_o      = ce_q;
  assign departure_ns_o = dep_q;

endmodule

### rtl/per_flow_departure_time_pacer_core.sv
// per_flow_departure_time_pacer_core: top level of the per-flow departure-time pacer.
// Depends on edtp_pkg, edtp_in_if, edtp_out_if, edtp_ctrl, edtp_dp, edtp_ram.
// Each beat on in_i describes one packet; exactly one verdict beat comes out on out_o
// for it, in order. For a known flow with a nonzero rate the block computes the gap
// length * 1e9 / rate with a restoring divider that retires one quotient bit per cycle
// (46 bits), adds it to the flow's stored last departure and compares against the later
// of the packet timestamp and now. Such a packet goes from accept through a multiply/read
// step, the divider loop, sum, compare and finish; a new beat is accepted only after the
// finish step. Unknown flows and zero rates skip the divider and go from accept straight
// to finish. The result sits in an output register, so a stalled consumer only holds
// the block at the finish step. After reset the flow store (one ram word per flow: a
// valid bit and a 64-bit departure) is cleared one entry a cycle with in_i.ready low;
// horizon writes on the configuration port are taken at any time but should only be
// made while the block is idle.
`timescale 1ns / 1ps

module per_flow_departure_time_pacer_core import edtp_pkg::*; #(
  parameter int unsigned FLOW_COUNT = FLOW_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  edtp_in_if.sink               in_i,
  edtp_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // horizon registers
  logic [HOR_W-1:0] drop_horizon_q, drop_horizon_d;
  logic [HOR_W-1:0] mark_horizon_q, mark_horizon_d;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // register writes: index picks the horizon, unknown indexes are ignored
  always_comb begin
    drop_horizon_d = drop_horizon_q;
    mark_horizon_d = mark_horizon_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DROP_HORIZON: drop_horizon_d = cfg_data_i;
        CFG_MARK_HORIZON: mark_horizon_d = cfg_data_i;
        default: begin
          drop_horizon_d = drop_horizon_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_horizon_q <= DROP_HORIZON_RESET;
      mark_horizon_q <= MARK_HORIZON_RESET;
    end else begin
      drop_horizon_q <= drop_horizon_d;
      mark_horizon_q <= mark_horizon_d;
    end
  end

  // sequencer: clear sweep, accept, load, divide, sum, compare, finish
  edtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: descriptor capture, flow store, gap divider, result register
  edtp_dp #(
    .FLOW_COUNT (FLOW_COUNT)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .drop_horizon_i       (drop_horizon_q),
    .mark_horizon_i       (mark_horizon_q),
    .flow_index_i         (in_i.flow_index),
    .flow_known_i         (in_i.flow_known),
    .rate_bytes_per_sec_i (in_i.rate_bytes_per_sec),
    .packet_length_i      (in_i.packet_length),
    .packet_time_ns_i     (in_i.packet_time_ns),
    .now_ns_i             (in_i.now_ns),
    .out_ready_i          (out_o.ready),
    .out_valid_o          (out_o.valid),
    .verdict_o            (out_o.verdict),
    .ce_mark_o            (out_o.ce_mark),
    .departure_ns_o       (out_o.departure_ns)
  );

endmodule

### dv/edtp_pacer_checker.sv
// edtp_pacer_checker: watches the descriptor, verdict and horizon ports of the pacer,
// predicts every verdict beat from its own flow store and compares in order
// depends on edtp_pkg, edtp_in_if and edtp_out_if
`timescale 1ns / 1ps

module edtp_pacer_checker import edtp_pkg::*; #(
  parameter int unsigned FLOW_COUNT = FLOW_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  edtp_in_if                    in_mon,
  edtp_out_if                   out_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    verdict_e          verdict;
    logic              ce_mark;
    logic [TIME_W-1:0] departure_ns;
  } departure_t;

  departure_t        due_q[$];
  departure_t        due;
  logic [TIME_W-1:0] flow_last [FLOW_COUNT];
  logic              flow_seen [FLOW_COUNT];
  logic [HOR_W-1:0]  drop_hor;
  logic [HOR_W-1:0]  mark_hor;
  int                fails;

  // updates the flow store the way the block does and returns the verdict beat
  function automatic departure_t pace_packet(
    input logic [FLOW_IDX_W-1:0] flow,
    input logic                  known,
    input logic [RATE_W-1:0]     rate,
    input logic [LEN_W-1:0]      len,
    input logic [TIME_W-1:0]     ptime,
    input logic [TIME_W-1:0]     now
  );
    departure_t        r;
    int unsigned       slot;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] next_dep;
    logic [TIME_W-1:0] eff;
    logic [TIME_W-1:0] wait_ns;
    r.verdict      = VERDICT_PASS;
    r.ce_mark      = 1'b0;
    r.departure_ns = ptime;
    if (!known || rate == '0) return r;
    slot     = int'(flow) % FLOW_COUNT;
    gap      = (TIME_W'(len) * 64'd1000000000) / TIME_W'(rate);
    next_dep = flow_seen[slot] ? flow_last[slot] + gap : '0;
    eff      = (ptime < now) ? now : ptime;
    if (next_dep <= eff) begin
      flow_last[slot] = eff;
      flow_seen[slot] = 1'b1;
      return r;
    end
    wait_ns = next_dep - now;
    if (wait_ns >= TIME_W'(drop_hor)) begin
      r.verdict      = VERDICT_DROP;
      r.departure_ns = '0;
      return r;
    end
    r.verdict       = VERDICT_PACED;
    r.ce_mark       = (wait_ns >= TIME_W'(mark_hor));
    r.departure_ns  = next_dep;
    flow_last[slot] = next_dep;
    flow_seen[slot] = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FLOW_COUNT; i++) begin
        flow_last[i] = '0;
        flow_seen[i] = 1'b0;
      end
      drop_hor = DROP_HORIZON_RESET;
      mark_hor = MARK_HORIZON_RESET;
      due_q.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: verdict beat with none expected, got verdict %0d ce %0b dep %0h",
                   $time, out_mon.verdict, out_mon.ce_mark, out_mon.departure_ns);
          fails++;
        end else begin
          due = due_q.pop_front();
          if (out_mon.verdict !== due.verdict) begin
            $display("%0t: verdict mismatch, expected %0d, got %0d",
                     $time, due.verdict, out_mon.verdict);
            fails++;
          end
          if (out_mon.ce_mark !== due.ce_mark) begin
            $display("%0t: ce_mark mismatch, expected %0b, got %0b",
                     $time, due.ce_mark, out_mon.ce_mark);
            fails++;
          end
          if (out_mon.departure_ns !== due.departure_ns) begin
            $display("%0t: departure_ns mismatch, expected %0h, got %0h",
                     $time, due.departure_ns, out_mon.departure_ns);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        due_q.push_back(pace_packet(in_mon.flow_index, in_mon.flow_known,
                                    in_mon.rate_bytes_per_sec, in_mon.packet_length,
                                    in_mon.packet_time_ns, in_mon.now_ns));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DROP_HORIZON: drop_hor = cfg_data_i;
          CFG_MARK_HORIZON: mark_hor = cfg_data_i;
          default: ;
        endcase
      end
      pending_o    <= due_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

### dv/tb_per_flow_departure_time_pacer_core.sv
// tb_per_flow_departure_time_pacer_core: stimulus and verdict for the departure-time pacer
// drives descriptors and horizon writes, stalls the verdict side, checking is done by
// edtp_pacer_checker; depends on edtp_pkg, edtp_in_if, edtp_out_if and the block
`timescale 1ns / 1ps

module tb_per_flow_departure_time_pacer_core;
  import edtp_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  // descriptor beat taken at the last rising edge, read at the falling edge
  logic                  in_fire = 1'b0;
  // calm windows switch off the random idling on either side
  bit                    calm_src;
  bit                    calm_snk;
  // running time base for well-formed traffic
  logic [TIME_W-1:0]     clock_ns;
  int                    fail_count;
  int                    pending;

  edtp_in_if  in_bus ();
  edtp_out_if out_bus ();

  per_flow_departure_time_pacer_core #(
    .FLOW_COUNT(FLOW_COUNT_DEF)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_bus),
    .out_o     (out_bus),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  edtp_pacer_checker #(
    .FLOW_COUNT(FLOW_COUNT_DEF)
  ) u_pace_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) in_fire <= in_bus.valid && in_bus.ready;

  // verdict side back-pressure, about 7 stalls in a hundred outside calm windows
  always @(negedge clk_i) out_bus.ready <= calm_snk || ($urandom_range(99) >= 7);

  // one descriptor beat; entered at a falling edge, returns at the falling edge
  // right after the beat was taken
  task automatic drive_packet(
    input logic [FLOW_IDX_W-1:0] flow,
    input logic                  known,
    input logic [RATE_W-1:0]     rate,
    input logic [LEN_W-1:0]      len,
    input logic [TIME_W-1:0]     ptime,
    input logic [TIME_W-1:0]     now
  );
    while (!calm_src && $urandom_range(99) < 7) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid              <= 1'b1;
    in_bus.flow_index         <= flow;
    in_bus.flow_known         <= known;
    in_bus.rate_bytes_per_sec <= rate;
    in_bus.packet_length      <= len;
    in_bus.packet_time_ns     <= ptime;
    in_bus.now_ns             <= now;
    do @(negedge clk_i); while (!in_fire);
  endtask

  // hold the sender until every verdict is back, then let the datapath settle
  task automatic drain_verdicts();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  // horizon writes, only ever made with the block drained
  task automatic set_horizons(input logic [HOR_W-1:0] drop_ns, input logic [HOR_W-1:0] mark_ns);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_DROP_HORIZON;
    cfg_data <= drop_ns;
    @(negedge clk_i);
    cfg_idx  <= CFG_MARK_HORIZON;
    cfg_data <= mark_ns;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    @(negedge clk_i);
  endtask

  // edge cases at the reset horizons (drop 2 s, mark 0.5 s)
  task automatic directed_packets();
    // unknown flow and zero rate pass the timestamp through untouched
    drive_packet(8'd0, 1'b0, 32'd1000, 16'd100, 64'd5, 64'd7);
    drive_packet(8'd255, 1'b1, 32'd0, 16'hFFFF, '1, '1);
    // first packet of a flow: nothing stored, passes and stores now
    drive_packet(8'd0, 1'b1, 32'd1000000000, 16'd1000, 64'd1000, 64'd1000);
    // gap 1000 ns, paced below the mark horizon
    drive_packet(8'd0, 1'b1, 32'd1000000000, 16'd1000, 64'd1000, 64'd1000);
    // huge gaps, dropped, store untouched
    drive_packet(8'd0, 1'b1, 32'd100, 16'hFFFF, 64'd1000, 64'd1000);
    drive_packet(8'd0, 1'b1, 32'd1, 16'd1000, 64'd1000, 64'd1000);
    // gap 1 s: paced with ce mark
    drive_packet(8'd0, 1'b1, 32'd1, 16'd1, 64'd1000, 64'd1000);
    // zero length: next departure is the stored one, still marked
    drive_packet(8'd0, 1'b1, 32'd7, 16'd0, 64'd1000, 64'd1000);
    // far in the future: passes and restores the effective time
    drive_packet(8'd0, 1'b1, 32'd1000000000, 16'd1000, 64'd3000000000, 64'd3000000000);
    // timestamp later than now decides the effective time
    drive_packet(8'd1, 1'b1, 32'd1000000000, 16'd10, 64'd5000, 64'd100);
    drive_packet(8'd1, 1'b1, 32'hFFFFFFFF, 16'hFFFF, 64'd100, 64'd100);
    drive_packet(8'd1, 1'b1, 32'd1000000000, 16'd10, 64'd1000000, 64'd200);
    // sum wraps past 2^64 and lands in a small paced departure
    drive_packet(8'd255, 1'b1, 32'd1000000000, 16'd1, 64'hFFFF_FFFF_FFFF_FF9C, 64'd0);
    drive_packet(8'd255, 1'b1, 32'd1000000000, 16'd1000, 64'd0, 64'd0);
    // next departure exactly at the effective time passes
    drive_packet(8'd128, 1'b1, 32'd1000000000, 16'd1, 64'd10000, 64'd10000);
    drive_packet(8'd128, 1'b1, 32'd1000000000, 16'd500, 64'd10500, 64'd10000);
    // wait exactly at the drop horizon, exactly at the mark horizon, one below
    drive_packet(8'd128, 1'b1, 32'd1, 16'd2, 64'd0, 64'd10500);
    drive_packet(8'd128, 1'b1, 32'd2, 16'd1, 64'd10500, 64'd10500);
    drive_packet(8'd128, 1'b1, 32'd2, 16'd1, 64'd500010501, 64'd500010501);
    // all fields at their maximum, then a wrapping drop from the top of time
    drive_packet(8'd255, 1'b1, 32'hFFFFFFFF, 16'hFFFF, '1, '1);
    drive_packet(8'd255, 1'b1, 32'd1, 16'hFFFF, 64'd0, 64'd0);
  endtask

  // mostly well-formed traffic on a few flows with gaps near the given scale, plus noise
  task automatic random_phase(
    input int unsigned       n_items,
    input logic [TIME_W-1:0] scale,
    input logic [7:0]        flow_base,
    input bit                mid_pause
  );
    logic [TIME_W-1:0]     step;
    logic [TIME_W-1:0]     tgap;
    logic [TIME_W-1:0]     quot;
    logic [TIME_W-1:0]     ptime;
    logic [FLOW_IDX_W-1:0] flow;
    logic                  known;
    logic [RATE_W-1:0]     rate;
    logic [LEN_W-1:0]      len;
    int unsigned           kind;
    for (int unsigned i = 0; i < n_items; i++) begin
      // a long stretch with no idling on either side
      calm_src = (i >= 60 && i < 110);
      calm_snk = calm_src;
      kind = $urandom_range(99);
      if (kind < 10) begin
        // noise: every field fully random
        drive_packet(FLOW_IDX_W'($urandom), 1'($urandom), $urandom, LEN_W'($urandom),
                     {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        step = ($urandom_range(9) == 0) ? scale * 4 : scale;
        clock_ns = clock_ns + ({$urandom, $urandom} % (step + 1));
        kind = $urandom_range(99);
        if (kind < 70)
          ptime = clock_ns;
        else if (kind < 90)
          ptime = clock_ns + ({$urandom, $urandom} % (scale + 1));
        else
          ptime = clock_ns - ({$urandom, $urandom} % (scale + 1));
        flow = ($urandom_range(19) == 0) ? FLOW_IDX_W'($urandom)
                                         : flow_base + FLOW_IDX_W'($urandom_range(5));
        len  = ($urandom_range(15) == 0) ? LEN_W'($urandom)
                                         : LEN_W'($urandom_range(1518, 64));
        // pick the rate that gives a gap around the scale
        tgap = {$urandom, $urandom} % (scale * 2 + 1);
        if (tgap == '0) begin
          rate = '1;
        end else begin
          quot = (TIME_W'(len) * 64'd1000000000) / tgap;
          if (quot == '0)
            rate = 32'd1;
          else if (quot > 64'hFFFF_FFFF)
            rate = '1;
          else
            rate = quot[RATE_W-1:0];
        end
        known = ($urandom_range(19) != 0);
        if ($urandom_range(32) == 0) rate = '0;
        drive_packet(flow, known, rate, len, ptime, clock_ns);
      end
      if (mid_pause && i == n_items / 2) drain_verdicts();
    end
    calm_src = 1'b0;
    calm_snk = 1'b0;
  endtask

  initial begin
    logic [HOR_W-1:0] rnd_drop;
    in_bus.valid              = 1'b0;
    in_bus.flow_index         = '0;
    in_bus.flow_known         = 1'b0;
    in_bus.rate_bytes_per_sec = '0;
    in_bus.packet_length      = '0;
    in_bus.packet_time_ns     = '0;
    in_bus.now_ns             = '0;
    out_bus.ready             = 1'b0;
    cfg_we                    = 1'b0;
    cfg_idx                   = CFG_DROP_HORIZON;
    cfg_data                  = '0;
    calm_src                  = 1'b0;
    calm_snk                  = 1'b0;
    clock_ns                  = 64'd1000;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // the store clear after reset holds ready low; drive_packet just waits it out
    directed_packets();
    drain_verdicts();

    // reset horizons, second-scale gaps
    random_phase(200, 64'd1000000000, 8'd10, 1'b0);
    drain_verdicts();
    // microsecond horizons, with a pause halfway through
    set_horizons(32'd20000, 32'd5000);
    random_phase(200, 64'd5000, 8'd20, 1'b1);
    drain_verdicts();
    // zero horizons: every paced packet turns into a drop
    set_horizons('0, '0);
    random_phase(200, 64'd2000, 8'd30, 1'b0);
    drain_verdicts();
    // both horizons at their maximum, waits pile up toward them
    set_horizons('1, '1);
    clock_ns = {$urandom, $urandom};
    random_phase(200, 64'd2000000000, 8'd40, 1'b0);
    drain_verdicts();
    // every paced packet marked
    set_horizons('1, '0);
    random_phase(200, 64'd1000, 8'd50, 1'b0);
    drain_verdicts();
    // mark above drop: marks can never happen
    set_horizons(32'd1, '1);
    random_phase(200, 64'd1000, 8'd60, 1'b0);
    drain_verdicts();
    // random horizons with mark at or below drop
    rnd_drop = $urandom;
    set_horizons(rnd_drop, $urandom_range(rnd_drop));
    clock_ns = {$urandom, $urandom};
    random_phase(200, TIME_W'(rnd_drop / 4) + 64'd1, 8'd250, 1'b0);
    drain_verdicts();
    // back to the reset values
    set_horizons(DROP_HORIZON_RESET, MARK_HORIZON_RESET);
    random_phase(200, 64'd300000000, 8'd120, 1'b0);
    drain_verdicts();

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
